// ===== src/mte_pkg.sv =====
package mte_pkg;

	localparam int TICK_W = 28;
	localparam int MSG_MAX = 8;

	typedef enum logic [3:0] {
		FN_NOTE_OFF    = 4'd0,
		FN_NOTE_ON     = 4'd1,
		FN_KEY_PRESS   = 4'd2,
		FN_CONTROLLER  = 4'd3,
		FN_PROGRAM     = 4'd4,
		FN_CHAN_PRESS  = 4'd5,
		FN_PITCH_BEND  = 4'd6,
		FN_TEMPO       = 4'd7,
		FN_TIME_SIG    = 4'd8,
		FN_KEY_SIG     = 4'd9,
		FN_SMPTE       = 4'd10,
		FN_END_TRACK   = 4'd11
	} func_t;

	localparam logic [3:0] STATUS_BASE   = 4'h8;
	localparam logic [7:0] META_STATUS   = 8'hFF;
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [7:0] META_TIME_SIG = 8'h58;
	localparam logic [7:0] META_KEY_SIG  = 8'h59;
	localparam logic [7:0] META_SMPTE    = 8'h54;
	localparam logic [7:0] META_EOT      = 8'h2F;
	localparam logic [7:0] LEN_TEMPO     = 8'h03;
	localparam logic [7:0] LEN_TIME_SIG  = 8'h04;
	localparam logic [7:0] LEN_KEY_SIG   = 8'h02;
	localparam logic [7:0] LEN_SMPTE     = 8'h05;
	localparam logic [7:0] LEN_EOT       = 8'h00;
	localparam logic [7:0] CONT_BIT      = 8'h80;

	typedef struct packed {
		func_t              func;
		logic [3:0]         channel;
		logic [7:0]         byte_a;
		logic [7:0]         byte_b;
		logic [7:0]         byte_c;
		logic [7:0]         byte_d;
		logic [7:0]         byte_e;
		logic [23:0]        wide_value;
		logic [TICK_W-1:0]  delta;
	} event_t;

endpackage

// ===== src/midi_track_event_encoder.sv =====
// Standard MIDI File track event encoder.
// The slave stream takes one event per request: tuser carries the event kind,
// tdata carries tick, channel, the five data bytes and the wide value. The
// master stream gives the encoded track bytes one per request in tdata, with
// tlast high on the final byte of each event.
// An accepted event is first held in an input stage, where its delta from
// the stored last tick is formed and the last tick is updated. It then moves
// into a byte buffer that is shifted out one byte per cycle while the receiver
// is ready; an event passes the input stage, then the byte buffer, to the output.
// Throughput is one output byte per cycle while the receiver is ready; an event
// has from 3 to DELTA_BYTES + 8 bytes. The input stage refills while the buffer
// drains, so events stream with no gap between them.
// Event kinds 12 to 15 are dropped at the input with no bytes and no change
// to the last tick. End of track sends 00 FF 2F 00 and clears the last tick.
// Reset clears the last tick and empties both stages.
// When the receiver stalls, the current byte holds and the buffer waits; one
// further event may be taken into the input stage, after which tready drops.
module midi_track_event_encoder #(
	parameter int DELTA_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tick [27:0], channel [31:28], byte_a [39:32], byte_b [47:40], byte_c [55:48],
	// byte_d [63:56], byte_e [71:64], wide_value [95:72]
	input  logic [95:0] s_tdata,
	// func [3:0]
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte [7:0]
	output logic [7:0]  m_tdata,
	// last
	output logic        m_tlast
);

	localparam int MAX_BYTES = DELTA_BYTES + mte_pkg::MSG_MAX;
	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int DX_W = 7 * DELTA_BYTES;
	localparam int GI_W = (DELTA_BYTES > 1) ? $clog2(DELTA_BYTES) : 1;

	logic [mte_pkg::TICK_W-1:0] tick_in;
	logic [mte_pkg::TICK_W-1:0] last_tick_q;
	logic [mte_pkg::TICK_W-1:0] delta_in;
	logic                       s_accept;
	logic                       func_ok;
	mte_pkg::func_t             func_in;

	mte_pkg::event_t            ev_s1;
	logic                       valid_s1;

	logic [7:0]                 buf_s2 [MAX_BYTES];
	logic [CNT_W-1:0]           cnt_s2;
	logic                       m_take;
	logic                       load_s2;

	logic [7:0]                 msg [mte_pkg::MSG_MAX];
	logic [3:0]                 msg_n;
	logic [7:0]                 status;
	logic                       over;
	logic [DX_W-1:0]            delta_x;
	logic [6:0]                 grp [DELTA_BYTES];
	logic [CNT_W-1:0]           groups;
	logic [7:0]                 build [MAX_BYTES];

	assign tick_in  = s_tdata[27:0];
	assign func_in  = mte_pkg::func_t'(s_tuser);
	assign func_ok  = s_tuser inside {[mte_pkg::FN_NOTE_OFF:mte_pkg::FN_END_TRACK]};
	assign s_tready = !valid_s1;
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		if (func_in == mte_pkg::FN_END_TRACK || tick_in < last_tick_q) begin
			delta_in = '0;
		end else begin
			delta_in = tick_in - last_tick_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_tick_q <= '0;
		end else begin
			if (s_accept && func_ok) begin
				valid_s1    <= 1'b1;
				last_tick_q <= (func_in == mte_pkg::FN_END_TRACK) ? '0 : tick_in;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && func_ok) begin
			ev_s1.func       <= func_in;
			ev_s1.channel    <= s_tdata[31:28];
			ev_s1.byte_a     <= s_tdata[39:32];
			ev_s1.byte_b     <= s_tdata[47:40];
			ev_s1.byte_c     <= s_tdata[55:48];
			ev_s1.byte_d     <= s_tdata[63:56];
			ev_s1.byte_e     <= s_tdata[71:64];
			ev_s1.wide_value <= s_tdata[95:72];
			ev_s1.delta      <= delta_in;
		end
	end

	// Message bytes that follow the delta.
	always_comb begin
		status = {4'(ev_s1.func) + mte_pkg::STATUS_BASE, ev_s1.channel};
		for (int k = 0; k < mte_pkg::MSG_MAX; k++) begin
			msg[k] = '0;
		end
		msg_n = 4'd0;
		case (ev_s1.func)
			mte_pkg::FN_NOTE_OFF, mte_pkg::FN_NOTE_ON, mte_pkg::FN_KEY_PRESS,
			mte_pkg::FN_CONTROLLER: begin
				msg[0] = status;
				msg[1] = ev_s1.byte_a;
				msg[2] = ev_s1.byte_b;
				msg_n  = 4'd3;
			end
			mte_pkg::FN_PROGRAM, mte_pkg::FN_CHAN_PRESS: begin
				msg[0] = status;
				msg[1] = ev_s1.byte_a;
				msg_n  = 4'd2;
			end
			mte_pkg::FN_PITCH_BEND: begin
				msg[0] = status;
				msg[1] = {1'b0, ev_s1.wide_value[6:0]};
				msg[2] = {1'b0, ev_s1.wide_value[13:7]};
				msg_n  = 4'd3;
			end
			mte_pkg::FN_TEMPO: begin
				msg[0] = mte_pkg::META_STATUS;
				msg[1] = mte_pkg::META_TEMPO;
				msg[2] = mte_pkg::LEN_TEMPO;
				msg[3] = ev_s1.wide_value[23:16];
				msg[4] = ev_s1.wide_value[15:8];
				msg[5] = ev_s1.wide_value[7:0];
				msg_n  = 4'd6;
			end
			mte_pkg::FN_TIME_SIG: begin
				msg[0] = mte_pkg::META_STATUS;
				msg[1] = mte_pkg::META_TIME_SIG;
				msg[2] = mte_pkg::LEN_TIME_SIG;
				msg[3] = ev_s1.byte_a;
				msg[4] = ev_s1.byte_b;
				msg[5] = ev_s1.byte_c;
				msg[6] = ev_s1.byte_d;
				msg_n  = 4'd7;
			end
			mte_pkg::FN_KEY_SIG: begin
				msg[0] = mte_pkg::META_STATUS;
				msg[1] = mte_pkg::META_KEY_SIG;
				msg[2] = mte_pkg::LEN_KEY_SIG;
				msg[3] = ev_s1.byte_a;
				msg[4] = ev_s1.byte_b;
				msg_n  = 4'd5;
			end
			mte_pkg::FN_SMPTE: begin
				msg[0] = mte_pkg::META_STATUS;
				msg[1] = mte_pkg::META_SMPTE;
				msg[2] = mte_pkg::LEN_SMPTE;
				msg[3] = ev_s1.byte_a;
				msg[4] = ev_s1.byte_b;
				msg[5] = ev_s1.byte_c;
				msg[6] = ev_s1.byte_d;
				msg[7] = ev_s1.byte_e;
				msg_n  = 4'd8;
			end
			mte_pkg::FN_END_TRACK: begin
				msg[0] = mte_pkg::META_STATUS;
				msg[1] = mte_pkg::META_EOT;
				msg[2] = mte_pkg::LEN_EOT;
				msg_n  = 4'd3;
			end
			default: begin
				msg_n = 4'd0;
			end
		endcase
	end

	// Delta as a variable-length quantity, followed by the message bytes.
	always_comb begin
		int gi;
		int mi;
		over    = |(ev_s1.delta >> DX_W);
		delta_x = over ? '1 : DX_W'(ev_s1.delta);
		groups  = CNT_W'(1);
		for (int g = 0; g < DELTA_BYTES; g++) begin
			grp[g] = delta_x[7*g +: 7];
		end
		for (int g = 1; g < DELTA_BYTES; g++) begin
			if ((delta_x >> (7 * g)) != '0) begin
				groups = CNT_W'(g + 1);
			end
		end
		for (int i = 0; i < MAX_BYTES; i++) begin
			gi = 0;
			mi = 0;
			if (i < int'(groups)) begin
				gi = int'(groups) - 1 - i;
				build[i] = {(gi != 0), grp[GI_W'(gi)]};
			end else begin
				mi = i - int'(groups);
				if (mi < int'(msg_n)) begin
					build[i] = msg[3'(mi)];
				end else begin
					build[i] = '0;
				end
			end
		end
	end

	assign m_tvalid = (cnt_s2 != '0);
	assign m_take   = m_tvalid && m_tready;
	assign load_s2  = valid_s1 && (cnt_s2 == '0 || (cnt_s2 == CNT_W'(1) && m_tready));
	assign m_tdata  = buf_s2[0];
	assign m_tlast  = (cnt_s2 == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else begin
			if (load_s2) begin
				cnt_s2 <= groups + CNT_W'(msg_n);
			end else if (m_take) begin
				cnt_s2 <= cnt_s2 - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			buf_s2 <= build;
		end else if (m_take) begin
			for (int i = 0; i < MAX_BYTES - 1; i++) begin
				buf_s2[i] <= buf_s2[i + 1];
			end
			buf_s2[MAX_BYTES - 1] <= '0;
		end
	end

`ifndef SYNTHESIS
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tuser == mte_pkg::FN_END_TRACK |=> last_tick_q == '0)
		else $error("last tick not cleared by end of track");

	a_tick_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tuser < mte_pkg::FN_END_TRACK |=> last_tick_q == $past(tick_in))
		else $error("last tick not updated by event");

	a_load_fills: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cnt_s2 == '0 |=> cnt_s2 != '0 && !valid_s1)
		else $error("waiting event not moved into the output buffer");
`endif

endmodule

// ===== sim/midi_track_event_encoder_test.sv =====
module midi_track_event_encoder_test;

	localparam int DELTA_GROUPS = 4;
	localparam int MAX_BYTES = 12;
	localparam int RANDOM_EVENTS = 125;
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [3:0]  func;
		logic [27:0] tick;
		logic [3:0]  channel;
		logic [7:0]  byte_a;
		logic [7:0]  byte_b;
		logic [7:0]  byte_c;
		logic [7:0]  byte_d;
		logic [7:0]  byte_e;
		logic [23:0] wide_value;
	} midi_event_t;

	typedef struct {
		midi_event_t ev;
		int          n_typed;
		logic [95:0] typed_bytes;
	} directed_row_t;

	typedef struct packed {
		logic [7:0] value;
		logic       is_last;
	} track_byte_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	logic        steady = 1'b0;
	int          cycles = 0;
	int          mismatches = 0;

	logic [27:0] trk_last_tick = '0;
	logic [7:0]  enc_bytes[MAX_BYTES];
	int          enc_len;
	track_byte_t pending_bytes[$];
	track_byte_t head_byte;
	directed_row_t directed_table[$];

	midi_track_event_encoder #(
		.DELTA_BYTES(DELTA_GROUPS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void put_byte(input logic [7:0] value);
		enc_bytes[enc_len] = value;
		enc_len++;
	endfunction

	// Encodes one event into enc_bytes and updates the stored last tick (cleared by end of track, kept for dropped kinds).
	function automatic void encode_event(input midi_event_t ev);
		longint cap;
		longint delta;
		int groups;
		logic [3:0] kind_nibble;
		cap = (longint'(1) << (7 * DELTA_GROUPS)) - 1;
		enc_len = 0;
		if (ev.func > mte_pkg::FN_END_TRACK)
			return;
		if (ev.func == mte_pkg::FN_END_TRACK) begin
			put_byte(8'h00);
			put_byte(mte_pkg::META_STATUS);
			put_byte(mte_pkg::META_EOT);
			put_byte(mte_pkg::LEN_EOT);
			trk_last_tick = '0;
			return;
		end
		delta = (ev.tick >= trk_last_tick) ? longint'(ev.tick) - longint'(trk_last_tick) : 0;
		if (delta > cap)
			delta = cap;
		groups = 1;
		while (groups < DELTA_GROUPS && (delta >> (7 * groups)) != 0)
			groups++;
		for (int g = groups - 1; g > 0; g--)
			put_byte(8'((delta >> (7 * g)) & 8'h7F) | mte_pkg::CONT_BIT);
		put_byte(8'(delta & 8'h7F));
		trk_last_tick = ev.tick;
		kind_nibble = mte_pkg::STATUS_BASE + ev.func;
		case (ev.func)
			mte_pkg::FN_NOTE_OFF, mte_pkg::FN_NOTE_ON, mte_pkg::FN_KEY_PRESS,
			mte_pkg::FN_CONTROLLER: begin
				put_byte({kind_nibble, ev.channel});
				put_byte(ev.byte_a);
				put_byte(ev.byte_b);
			end
			mte_pkg::FN_PROGRAM, mte_pkg::FN_CHAN_PRESS: begin
				put_byte({kind_nibble, ev.channel});
				put_byte(ev.byte_a);
			end
			mte_pkg::FN_PITCH_BEND: begin
				put_byte({kind_nibble, ev.channel});
				put_byte({1'b0, ev.wide_value[6:0]});
				put_byte({1'b0, ev.wide_value[13:7]});
			end
			mte_pkg::FN_TEMPO: begin
				put_byte(mte_pkg::META_STATUS);
				put_byte(mte_pkg::META_TEMPO);
				put_byte(mte_pkg::LEN_TEMPO);
				put_byte(ev.wide_value[23:16]);
				put_byte(ev.wide_value[15:8]);
				put_byte(ev.wide_value[7:0]);
			end
			mte_pkg::FN_TIME_SIG: begin
				put_byte(mte_pkg::META_STATUS);
				put_byte(mte_pkg::META_TIME_SIG);
				put_byte(mte_pkg::LEN_TIME_SIG);
				put_byte(ev.byte_a);
				put_byte(ev.byte_b);
				put_byte(ev.byte_c);
				put_byte(ev.byte_d);
			end
			mte_pkg::FN_KEY_SIG: begin
				put_byte(mte_pkg::META_STATUS);
				put_byte(mte_pkg::META_KEY_SIG);
				put_byte(mte_pkg::LEN_KEY_SIG);
				put_byte(ev.byte_a);
				put_byte(ev.byte_b);
			end
			default: begin
				put_byte(mte_pkg::META_STATUS);
				put_byte(mte_pkg::META_SMPTE);
				put_byte(mte_pkg::LEN_SMPTE);
				put_byte(ev.byte_a);
				put_byte(ev.byte_b);
				put_byte(ev.byte_c);
				put_byte(ev.byte_d);
				put_byte(ev.byte_e);
			end
		endcase
	endfunction

	function automatic midi_event_t make_event(input logic [3:0] func, input logic [27:0] tick,
			input logic [3:0] channel, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
			input logic [23:0] wide);
		midi_event_t ev;
		ev.func = func;
		ev.tick = tick;
		ev.channel = channel;
		ev.byte_a = a;
		ev.byte_b = b;
		ev.byte_c = c;
		ev.byte_d = d;
		ev.byte_e = e;
		ev.wide_value = wide;
		return ev;
	endfunction

	// A negative count leaves the expected bytes to the predictor.
	function automatic void add_row(input midi_event_t ev, input int n_typed,
			input logic [95:0] typed);
		directed_row_t row;
		row.ev = ev;
		row.n_typed = n_typed;
		row.typed_bytes = (n_typed > 0) ? typed << (8 * (MAX_BYTES - n_typed)) : '0;
		directed_table.push_back(row);
	endfunction

	function automatic void report_mismatch(input string what, input logic [8:0] expected,
			input logic [8:0] actual);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s expected byte %02h last %b, got byte %02h last %b",
				cycles, what, expected[8:1], expected[0], actual[8:1], actual[0]);
	endfunction

	task automatic send_event(input midi_event_t ev, input int n_typed,
			input logic [95:0] typed);
		track_byte_t tb;
		if (!steady) begin
			while ($urandom_range(0, 99) < 34) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= ev.func;
		s_tdata <= {ev.wide_value, ev.byte_e, ev.byte_d, ev.byte_c, ev.byte_b, ev.byte_a,
			ev.channel, ev.tick};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		encode_event(ev);
		if (n_typed >= 0) begin
			for (int k = 0; k < n_typed; k++) begin
				tb.value = typed[95 - 8 * k -: 8];
				tb.is_last = (k == n_typed - 1);
				pending_bytes.push_back(tb);
			end
		end else begin
			for (int k = 0; k < enc_len; k++) begin
				tb.value = enc_bytes[k];
				tb.is_last = (k == enc_len - 1);
				pending_bytes.push_back(tb);
			end
		end
	endtask

	function automatic midi_event_t random_event();
		midi_event_t ev;
		int pick;
		int tick_mode;
		longint next_tick;
		ev = make_event(4'(mte_pkg::FN_NOTE_ON), '0, 4'($urandom_range(0, 15)), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 5)
			ev.func = 4'($urandom_range(12, 15));
		else if (pick < 12)
			ev.func = mte_pkg::FN_END_TRACK;
		else
			ev.func = 4'($urandom_range(0, 10));
		tick_mode = $urandom_range(0, 99);
		if (tick_mode < 70)
			next_tick = longint'(trk_last_tick) + $urandom_range(0, 300);
		else if (tick_mode < 80)
			next_tick = longint'(trk_last_tick) + $urandom_range(0, 1 << 21);
		else if (tick_mode < 88)
			next_tick = $urandom_range(0, trk_last_tick);
		else
			next_tick = $urandom_range(0, 28'hFFFFFFF);
		if (next_tick > 28'hFFFFFFF)
			next_tick = 28'hFFFFFFF;
		ev.tick = 28'(next_tick);
		return ev;
	endfunction

	always @(posedge clk)
		m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 34);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected byte", 9'h0, {m_tdata, m_tlast});
			end else begin
				head_byte = pending_bytes.pop_front();
				if (m_tdata !== head_byte.value)
					report_mismatch("tdata", {head_byte.value, head_byte.is_last},
						{m_tdata, m_tlast});
				if (m_tlast !== head_byte.is_last)
					report_mismatch("tlast", {head_byte.value, head_byte.is_last},
						{m_tdata, m_tlast});
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		midi_event_t ev;
		int accepted;

		add_row(make_event(4'(mte_pkg::FN_NOTE_ON), 28'd0, 4'd0, 8'h3C, 8'h64, 8'h00, 8'h00,
			8'h00, 24'h0), 4, {8'h00, 8'h90, 8'h3C, 8'h64});
		add_row(make_event(4'(mte_pkg::FN_END_TRACK), 28'h5A5A5A5, 4'd0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 24'h0), 4, {8'h00, 8'hFF, 8'h2F, 8'h00});
		add_row(make_event(4'(mte_pkg::FN_NOTE_OFF), 28'hFFFFFFF, 4'hF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 24'hFFFFFF), 7, {8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h8F, 8'hFF, 8'hFF});
		add_row(make_event(4'(mte_pkg::FN_PROGRAM), 28'd0, 4'd5, 8'h80, 8'h00, 8'h00, 8'h00,
			8'h00, 24'h0), 3, {8'h00, 8'hC5, 8'h80});
		add_row(make_event(4'd12, 28'd500, 4'd1, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 24'h1),
			0, '0);
		add_row(make_event(4'd15, 28'hFFFFFFF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			24'hFFFFFF), 0, '0);
		add_row(make_event(4'(mte_pkg::FN_KEY_PRESS), 28'd127, 4'd2, 8'h40, 8'h7F, 8'h00,
			8'h00, 8'h00, 24'h0), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_CONTROLLER), 28'd255, 4'd3, 8'h07, 8'h00, 8'h00,
			8'h00, 8'h00, 24'h0), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_CHAN_PRESS), 28'd16638, 4'd4, 8'h55, 8'hAA, 8'h00,
			8'h00, 8'h00, 24'h0), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_PITCH_BEND), 28'd33022, 4'd6, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 24'hFFFFFF), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_PITCH_BEND), 28'd33022, 4'd9, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 24'h002000), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_TEMPO), 28'd2130173, 4'd0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 24'h07A120), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_TEMPO), 28'd4227325, 4'd0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 24'hFFFFFF), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_TIME_SIG), 28'd4227326, 4'd0, 8'h04, 8'h02, 8'h18,
			8'h08, 8'h00, 24'h0), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_KEY_SIG), 28'd4227200, 4'd0, 8'hFD, 8'h01, 8'h00,
			8'h00, 8'h00, 24'h0), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_SMPTE), 28'd4227200, 4'd0, 8'hE1, 8'h3B, 8'h3B,
			8'h1D, 8'h63, 24'h0), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_SMPTE), 28'd4227201, 4'd0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 24'h0), -1, '0);
		add_row(make_event(4'(mte_pkg::FN_NOTE_ON), 28'd4227202, 4'hA, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 24'h0), -1, '0);
		add_row(make_event(4'd13, 28'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 24'h0),
			-1, '0);
		add_row(make_event(4'd14, 28'd1, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 24'h0),
			-1, '0);
		add_row(make_event(4'(mte_pkg::FN_END_TRACK), 28'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 24'h0), -1, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_table[i])
			send_event(directed_table[i].ev, directed_table[i].n_typed,
				directed_table[i].typed_bytes);

		accepted = 0;
		while (accepted < RANDOM_EVENTS) begin
			steady <= (accepted >= 50 && accepted < 90);
			ev = random_event();
			send_event(ev, -1, '0);
			if (ev.func <= mte_pkg::FN_END_TRACK)
				accepted++;
		end
		s_tvalid <= 1'b0;
		steady <= 1'b0;

		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
